FILE: hdl/tps_pkg.sv
package tps_pkg;

    // Parameter defaults
    localparam int MAX_RANK_DEF   = 8;
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;

    // Fixed field and register geometry
    localparam int DATA_W         = 32;
    localparam int CFG_W          = 64;
    localparam int CFG_ADDR_W     = 3;
    localparam int RANK_W         = 4;
    localparam int SLOT_BITS      = 16;
    localparam int SLOTS_PER_REG  = 4;
    localparam int PERM_BITS      = 3;
    localparam int PERM_SLOTS     = 8;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RANK     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_LO    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_HI    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_LO   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_HI   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PERM     = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic count_step;
        logic check;
        logic div_start;
        logic div_take;
        logic stride_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_dim;
        logic dim_zero;
        logic in_range;
        logic div_done;
    } t_sts;

endpackage

FILE: hdl/tps_div.sv
module tps_div #(
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF,
    parameter int DIM_BITS   = tps_pkg::DIM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [INDEX_BITS-1:0] i_dividend,
    input  logic [DIM_BITS-1:0]   i_divisor,
    output logic                  o_done,
    output logic [INDEX_BITS-1:0] o_quotient,
    output logic [DIM_BITS-1:0]   o_remainder
);
    import tps_pkg::*;

    localparam int CW = $clog2(INDEX_BITS);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [INDEX_BITS-1:0] r_quo, n_quo;
    logic [DIM_BITS-1:0]   r_rem, n_rem;
    logic [DIM_BITS-1:0]   r_dvs, n_dvs;

    logic [DIM_BITS:0]     w_shift;
    logic [DIM_BITS:0]     w_diff;
    logic                  w_ge;

    // Restoring division, one quotient bit a cycle; dividend bits leave r_quo at the top
    // while quotient bits enter at the bottom.
    assign w_shift = {r_rem, r_quo[INDEX_BITS-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(INDEX_BITS - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[INDEX_BITS-2:0], w_ge};
            n_rem = w_ge ? w_diff[DIM_BITS-1:0] : w_shift[DIM_BITS-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

endmodule

FILE: hdl/tps_dp.sv
module tps_dp #(
    parameter int MAX_RANK   = tps_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS   = tps_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_wr_en,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]               i_cfg_addr,
    input  logic [tps_pkg::CFG_W-1:0]                    i_cfg_wdata,
    input  logic [tps_pkg::DATA_W-1:0]                   i_dest_index,
    input  tps_pkg::t_cmd                                i_cmd,
    output tps_pkg::t_sts                                o_sts,
    output logic [tps_pkg::DATA_W-1:0]                   o_source_index,
    output logic                                         o_in_range
);
    import tps_pkg::*;

    localparam int DW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W = INDEX_BITS + 1;
    localparam int PW    = CNT_W + DIM_BITS;
    localparam int MW    = INDEX_BITS + DIM_BITS;
    localparam logic [CNT_W-1:0] CAP = {1'b1, {INDEX_BITS{1'b0}}};

    // Configuration
    logic [RANK_W-1:0]    r_rank;
    logic [DIM_BITS-1:0]  r_in_dim  [MAX_RANK];
    logic [DIM_BITS-1:0]  r_out_dim [MAX_RANK];
    logic [PERM_BITS-1:0] r_perm    [MAX_RANK];

    // Item state
    logic [INDEX_BITS-1:0] r_dest;
    logic [CNT_W-1:0]      r_count;
    logic [DW-1:0]         r_dim;
    logic [INDEX_BITS-1:0] r_tmp;
    logic [DIM_BITS-1:0]   r_coord   [PERM_SLOTS];
    logic [PERM_SLOTS-1:0] r_coord_v;
    logic [INDEX_BITS-1:0] r_src;
    logic [INDEX_BITS-1:0] r_stride;
    logic                  r_inr;
    logic [DATA_W-1:0]     r_out_src;
    logic                  r_out_inr;

    logic [DW-1:0]         w_last;
    logic [PW-1:0]         w_prod;
    logic [CNT_W-1:0]      w_count_sat;
    logic                  w_in_range;
    logic [PERM_BITS-1:0]  w_rd_slot;
    logic [PERM_BITS-1:0]  w_wr_slot;
    logic [DIM_BITS-1:0]   w_coord;
    logic [MW-1:0]         w_term;
    logic [MW-1:0]         w_stride_nx;
    logic                  w_div_done;
    logic [INDEX_BITS-1:0] w_quo;
    logic [DIM_BITS-1:0]   w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_W'(1);
            for (int k = 0; k < MAX_RANK; k++) begin
                r_in_dim[k]  <= DIM_BITS'(1);
                r_out_dim[k] <= DIM_BITS'(1);
                r_perm[k]    <= PERM_BITS'(k);
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_RANK: begin
                    r_rank <= i_cfg_wdata[RANK_W-1:0];
                end
                REG_IN_LO: begin
                    for (int k = 0; k < MAX_RANK; k++)
                        if (k < SLOTS_PER_REG)
                            r_in_dim[k] <= i_cfg_wdata[(k % SLOTS_PER_REG)*SLOT_BITS +: DIM_BITS];
                end
                REG_IN_HI: begin
                    for (int k = 0; k < MAX_RANK; k++)
                        if (k >= SLOTS_PER_REG)
                            r_in_dim[k] <= i_cfg_wdata[(k % SLOTS_PER_REG)*SLOT_BITS +: DIM_BITS];
                end
                REG_OUT_LO: begin
                    for (int k = 0; k < MAX_RANK; k++)
                        if (k < SLOTS_PER_REG)
                            r_out_dim[k] <= i_cfg_wdata[(k % SLOTS_PER_REG)*SLOT_BITS +: DIM_BITS];
                end
                REG_OUT_HI: begin
                    for (int k = 0; k < MAX_RANK; k++)
                        if (k >= SLOTS_PER_REG)
                            r_out_dim[k] <= i_cfg_wdata[(k % SLOTS_PER_REG)*SLOT_BITS +: DIM_BITS];
                end
                REG_PERM: begin
                    for (int k = 0; k < MAX_RANK; k++)
                        r_perm[k] <= i_cfg_wdata[k*PERM_BITS +: PERM_BITS];
                end
                default: begin
                end
            endcase
        end
    end

    // Rank zero counts as one, anything past MAX_RANK as MAX_RANK
    always_comb begin
        if (r_rank == '0)
            w_last = '0;
        else if (r_rank > RANK_W'(MAX_RANK))
            w_last = DW'(MAX_RANK - 1);
        else
            w_last = DW'(r_rank - 1'b1);
    end

    // Element count, saturated at 2^INDEX_BITS
    assign w_prod      = PW'(r_count) * PW'(r_out_dim[r_dim]);
    assign w_count_sat = (w_prod > PW'(CAP)) ? CAP : CNT_W'(w_prod);
    assign w_in_range  = {1'b0, r_dest} < r_count;

    assign w_wr_slot   = r_perm[r_dim];
    assign w_rd_slot   = PERM_BITS'(r_dim);
    assign w_coord     = r_coord_v[w_rd_slot] ? r_coord[w_rd_slot] : '0;
    assign w_term      = MW'(w_coord) * MW'(r_stride);
    assign w_stride_nx = MW'(r_in_dim[r_dim]) * MW'(r_stride);

    tps_div #(
        .INDEX_BITS (INDEX_BITS),
        .DIM_BITS   (DIM_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_tmp),
        .i_divisor   (r_out_dim[r_dim]),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_v <= '0;
            r_count   <= CNT_W'(1);
            r_dim     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_coord_v <= '0;
                r_count   <= CNT_W'(1);
                r_dim     <= '0;
            end
            if (i_cmd.count_step) begin
                r_count <= w_count_sat;
                r_dim   <= r_dim + 1'b1;
            end
            if (i_cmd.check)
                r_dim <= w_last;
            // Division runs from the last dimension down, so the first write to a slot
            // comes from the highest output dimension naming it: keep that one.
            if (i_cmd.div_take) begin
                if (!r_coord_v[w_wr_slot])
                    r_coord_v[w_wr_slot] <= 1'b1;
                r_dim <= (r_dim == '0) ? w_last : r_dim - 1'b1;
            end
            if (i_cmd.stride_step)
                r_dim <= r_dim - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_dest <= INDEX_BITS'(i_dest_index);
        if (i_cmd.check) begin
            r_tmp    <= r_dest;
            r_inr    <= w_in_range;
            r_src    <= '0;
            r_stride <= INDEX_BITS'(1);
        end
        if (i_cmd.div_take) begin
            r_tmp <= w_quo;
            if (!r_coord_v[w_wr_slot])
                r_coord[w_wr_slot] <= w_rem;
        end
        if (i_cmd.stride_step) begin
            r_src    <= r_src + w_term[INDEX_BITS-1:0];
            r_stride <= w_stride_nx[INDEX_BITS-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_src <= DATA_W'(r_src);
            r_out_inr <= r_inr;
        end
    end

    assign o_sts.last_dim = (r_dim == w_last);
    assign o_sts.dim_zero = (r_dim == '0);
    assign o_sts.in_range = w_in_range;
    assign o_sts.div_done = w_div_done;

    assign o_source_index = r_out_src;
    assign o_in_range     = r_out_inr;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("element count above saturation cap");

endmodule

FILE: hdl/tps_ctrl.sv
module tps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  tps_pkg::t_sts i_sts,
    output tps_pkg::t_cmd o_cmd
);
    import tps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_COUNT  = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DWAIT  = 7'b0010000,
        S_STRIDE = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_out_free;

    assign w_out_free = !r_ovalid || i_m_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count_step = 1'b1;
                if (i_sts.last_dim)
                    n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.in_range ? S_DSTART : S_DONE;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = i_sts.dim_zero ? S_STRIDE : S_DSTART;
                end
            end
            S_STRIDE: begin
                o_cmd.stride_step = 1'b1;
                if (i_sts.dim_zero)
                    n_state = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = o_cmd.out_load || (r_ovalid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DWAIT))
        else $error("division finished outside the wait state");

    a_load_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_tready && r_state == S_DONE) |=> (r_state == S_DONE))
        else $error("result dropped while output word still pending");

endmodule

FILE: hdl/tensor_permute_source_index.sv
// Channel   Dir  Signals                      Payload (lowest bit first)
// s stream  in   i_s_tvalid/o_s_tready        tdata: dest_index[31:0]
// m stream  out  o_m_tvalid/i_m_tready        tdata: source_index[31:0]; tuser: in_range
// cfg       in   i_cfg_wr_en/addr/wdata       rank, in_dims lo/hi, out_dims lo/hi, perm
//
// For a word in range the bit-serial divider runs once per dimension in use, last dimension first;
// a word out of range skips the division.
// One word is processed at a time; the next word is taken while the result still waits.
// Reset (synchronous, active low) gives rank 1, all sizes 1, identity permutation.
// A stalled output holds the result; work on the next word stops only at its own end.
module tensor_permute_source_index #(
    parameter int MAX_RANK   = tps_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS   = tps_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = tps_pkg::INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [tps_pkg::DATA_W-1:0]     i_s_tdata,   // dest_index
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tps_pkg::DATA_W-1:0]     o_m_tdata,   // source_index
    output logic                           o_m_tuser,   // in_range
    input  logic                           i_cfg_wr_en,
    input  logic [tps_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tps_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import tps_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tps_dp #(
        .MAX_RANK   (MAX_RANK),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_dest_index   (i_s_tdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_source_index (o_m_tdata),
        .o_in_range     (o_m_tuser)
    );

endmodule

FILE: test/tensor_permute_source_index_test.sv
`timescale 1ns / 100ps

module tensor_permute_source_index_test;
    import tps_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int WORDS_PER_SETTING = 38;
    localparam int SETTINGS_PER_PHASE = 7;
    localparam int IDLE_PHASES = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 320;
    localparam int HOLD_CYCLES = 1500;
    localparam int LONG_GAP_MAX = 350;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [63:0] COUNT_CAP = 64'h1_0000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] src;
        logic              ok;
    } t_mapped;

    typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_WORD_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_W-1:0]      value;   // register data, or dest_index in the low bits
        t_mapped               want;
    } t_stim_row;

    localparam t_mapped OUT_OF_RANGE = '{src: '0, ok: 1'b0};
    localparam t_mapped ORIGIN = '{src: '0, ok: 1'b1};

    localparam int DIRECTED_ROWS = 45;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // reset setting: a single element
        '{ROW_WORD_TYPED, REG_RANK, 64'd0, ORIGIN},
        '{ROW_WORD_TYPED, REG_RANK, 64'd1, OUT_OF_RANGE},
        '{ROW_WORD_TYPED, REG_RANK, 64'hFFFF_FFFF, OUT_OF_RANGE},
        // 2x3x4 view of a 4x3x2 tensor
        '{ROW_REG, REG_RANK, 64'd3, '0},
        '{ROW_REG, REG_IN_LO, 64'h0001_0002_0003_0004, '0},
        '{ROW_REG, REG_OUT_LO, 64'h0001_0004_0003_0002, '0},
        '{ROW_REG, REG_PERM, 64'h00FA_C60A, '0},
        '{ROW_WORD_TYPED, REG_RANK, 64'd0, ORIGIN},
        '{ROW_WORD, REG_RANK, 64'd23, '0},
        '{ROW_WORD_TYPED, REG_RANK, 64'd24, OUT_OF_RANGE},
        '{ROW_WORD, REG_RANK, 64'd7, '0},
        '{ROW_WORD, REG_RANK, 64'd13, '0},
        // full rank, every size 2, reversed order
        '{ROW_REG, REG_RANK, 64'd8, '0},
        '{ROW_REG, REG_IN_LO, 64'h0002_0002_0002_0002, '0},
        '{ROW_REG, REG_IN_HI, 64'h0002_0002_0002_0002, '0},
        '{ROW_REG, REG_OUT_LO, 64'h0002_0002_0002_0002, '0},
        '{ROW_REG, REG_OUT_HI, 64'h0002_0002_0002_0002, '0},
        '{ROW_REG, REG_PERM, 64'h0005_3977, '0},
        '{ROW_WORD, REG_RANK, 64'd255, '0},
        '{ROW_WORD, REG_RANK, 64'd1, '0},
        '{ROW_WORD_TYPED, REG_RANK, 64'd256, OUT_OF_RANGE},
        // a zero size in use empties the tensor
        '{ROW_REG, REG_OUT_HI, 64'h0002_0000_0002_0002, '0},
        '{ROW_WORD_TYPED, REG_RANK, 64'd0, OUT_OF_RANGE},
        // element count saturates, strides wrap
        '{ROW_REG, REG_IN_LO, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{ROW_REG, REG_IN_HI, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{ROW_REG, REG_OUT_LO, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{ROW_REG, REG_OUT_HI, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{ROW_WORD, REG_RANK, 64'hFFFF_FFFF, '0},
        '{ROW_WORD_TYPED, REG_RANK, 64'd0, ORIGIN},
        '{ROW_WORD, REG_RANK, 64'h8000_0000, '0},
        // rank zero acts as one; the reversed entry then points past the rank
        '{ROW_REG, REG_RANK, 64'd0, '0},
        '{ROW_REG, REG_OUT_LO, 64'h0001_0001_0001_0005, '0},
        '{ROW_WORD, REG_RANK, 64'd4, '0},
        '{ROW_WORD_TYPED, REG_RANK, 64'd5, OUT_OF_RANGE},
        // rank above the maximum acts as the maximum
        '{ROW_REG, REG_RANK, 64'd15, '0},
        '{ROW_WORD, REG_RANK, 64'hABCD_1234, '0},
        // repeated entries, sizes that disagree
        '{ROW_REG, REG_RANK, 64'd3, '0},
        '{ROW_REG, REG_OUT_LO, 64'h0001_0005_0004_0003, '0},
        '{ROW_REG, REG_IN_LO, 64'h0001_0007_0006_0005, '0},
        '{ROW_REG, REG_PERM, 64'h00FA_C609, '0},
        '{ROW_WORD, REG_RANK, 64'd59, '0},
        '{ROW_WORD, REG_RANK, 64'd37, '0},
        // unused indexes change nothing
        '{ROW_REG, REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{ROW_REG, REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{ROW_WORD, REG_RANK, 64'd37, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [DATA_W-1:0]     o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    // register copy
    logic [RANK_W-1:0] cfg_rank = 4'd1;
    logic [CFG_W-1:0]  cfg_in_lo = 64'h0001_0001_0001_0001;
    logic [CFG_W-1:0]  cfg_in_hi = 64'h0001_0001_0001_0001;
    logic [CFG_W-1:0]  cfg_out_lo = 64'h0001_0001_0001_0001;
    logic [CFG_W-1:0]  cfg_out_hi = 64'h0001_0001_0001_0001;
    logic [23:0]       cfg_perm = 24'hFAC688;

    t_mapped pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned fail_count = 0;
    int unsigned report_count = 0;
    int unsigned words_sent = 0;
    int unsigned reg_writes = 0;
    int unsigned results_checked = 0;
    int unsigned in_range_seen = 0;

    tensor_permute_source_index dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),     // dest_index
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),     // source_index
        .o_m_tuser   (o_m_tuser),     // in_range
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned rank_in_use(input logic [RANK_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_RANK_DEF) return MAX_RANK_DEF;
        return r;
    endfunction

    function automatic logic [SLOT_BITS-1:0] dim_size(input logic [CFG_W-1:0] lo,
                                                      input logic [CFG_W-1:0] hi,
                                                      input int d);
        if (d < SLOTS_PER_REG) return lo[(d % SLOTS_PER_REG)*SLOT_BITS +: SLOT_BITS];
        return hi[(d % SLOTS_PER_REG)*SLOT_BITS +: SLOT_BITS];
    endfunction

    function automatic logic [63:0] element_count();
        logic [63:0] cnt;
        cnt = 1;
        for (int d = 0; d < int'(rank_in_use(cfg_rank)); d++) begin
            cnt = cnt * dim_size(cfg_out_lo, cfg_out_hi, d);
            if (cnt > COUNT_CAP) cnt = COUNT_CAP;
        end
        return cnt;
    endfunction

    function automatic t_mapped map_source_index(input logic [DATA_W-1:0] dest);
        t_mapped           res;
        int                r;
        logic [DATA_W-1:0] rest, stride, acc;
        logic [DATA_W-1:0] out_c [PERM_SLOTS];
        logic [DATA_W-1:0] in_c [PERM_SLOTS];
        logic [SLOT_BITS-1:0] n;
        logic [PERM_BITS-1:0] p;
        res = OUT_OF_RANGE;
        r = rank_in_use(cfg_rank);
        if ({32'd0, dest} >= element_count()) return res;
        // peel coordinates off the last dimension first
        rest = dest;
        for (int d = r - 1; d >= 0; d--) begin
            n = dim_size(cfg_out_lo, cfg_out_hi, d);
            out_c[d] = rest % n;
            rest = rest / n;
        end
        for (int d = 0; d < PERM_SLOTS; d++) in_c[d] = '0;
        for (int d = 0; d < r; d++) begin
            p = cfg_perm[d*PERM_BITS +: PERM_BITS];
            in_c[p] = out_c[d];
        end
        acc = '0;
        stride = 1;
        for (int d = r - 1; d >= 0; d--) begin
            acc = acc + in_c[d] * stride;
            stride = stride * {16'd0, dim_size(cfg_in_lo, cfg_in_hi, d)};
        end
        res.src = acc;
        res.ok = 1'b1;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_dest();
        logic [63:0] cnt, lim;
        int unsigned pick;
        cnt = element_count();
        lim = cnt - 1;
        pick = $urandom_range(0, 9);
        if (cnt == 0 || pick == 9) return $urandom;
        if (pick < 7) return $urandom_range(0, lim[31:0]);
        if (pick == 7) return lim[31:0];
        if (cnt == COUNT_CAP) return $urandom;
        return cnt[31:0] + $urandom_range(0, 3);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            REG_RANK:   cfg_rank = value[RANK_W-1:0];
            REG_IN_LO:  cfg_in_lo = value;
            REG_IN_HI:  cfg_in_hi = value;
            REG_OUT_LO: cfg_out_lo = value;
            REG_OUT_HI: cfg_out_hi = value;
            REG_PERM:   cfg_perm = value[23:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Drop valid and drain every pending result before touching registers.
    task automatic await_idle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [DATA_W-1:0] dest, input logic typed,
                             input t_mapped want);
        if ($urandom_range(0, 999) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, LONG_GAP_MAX)) @(posedge i_clk);
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= dest;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(typed ? want : map_source_index(dest));
        words_sent++;
    endtask

    task automatic pick_setting();
        logic [CFG_W-1:0]     rank_val, in_lo, in_hi, out_lo, out_hi;
        logic [SLOT_BITS-1:0] sz;
        logic [23:0]          perm;
        logic [PERM_BITS-1:0] order [PERM_SLOTS];
        logic [PERM_BITS-1:0] t;
        logic                 wild_rank, wild_dims;
        int                   r, j;
        wild_rank = ($urandom_range(0, 9) == 0);
        wild_dims = ($urandom_range(0, 9) == 0);
        rank_val = wild_rank ? {$urandom, $urandom} : 64'($urandom_range(1, MAX_RANK_DEF));
        r = rank_in_use(rank_val[RANK_W-1:0]);
        for (int d = 0; d < PERM_SLOTS; d++) begin
            if (d >= r || wild_dims) begin
                sz = 16'($urandom);
            end else begin
                case ($urandom_range(0, 39))
                    0: sz = '0;
                    1: sz = '1;
                    2: sz = 16'($urandom);
                    default: sz = 16'($urandom_range(1, 6));
                endcase
            end
            if (d < SLOTS_PER_REG) out_lo[d*SLOT_BITS +: SLOT_BITS] = sz;
            else out_hi[(d-SLOTS_PER_REG)*SLOT_BITS +: SLOT_BITS] = sz;
            sz = $urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom);
            if (d < SLOTS_PER_REG) in_lo[d*SLOT_BITS +: SLOT_BITS] = sz;
            else in_hi[(d-SLOTS_PER_REG)*SLOT_BITS +: SLOT_BITS] = sz;
        end
        perm = 24'($urandom);
        // mostly a true permutation of the dimensions in use
        if ($urandom_range(0, 4) < 3) begin
            for (int k = 0; k < PERM_SLOTS; k++) order[k] = 3'(k);
            for (int k = r - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
            for (int d = 0; d < r; d++) perm[d*PERM_BITS +: PERM_BITS] = order[d];
        end
        write_reg(REG_RANK, rank_val);
        write_reg(REG_IN_LO, in_lo);
        write_reg(REG_IN_HI, in_hi);
        write_reg(REG_OUT_LO, out_lo);
        write_reg(REG_OUT_HI, out_hi);
        write_reg(REG_PERM, {40'd0, perm});
        i_cfg_wr_en <= 1'b0;
    endtask

    // receiver: random ready, occasional long stalls, forced hold-off on request
    always @(posedge i_clk) begin : drive_ready
        int unsigned hold_left;
        int unsigned hold_taken;
        if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left = HOLD_CYCLES;
        end else if (hold_left == 0 && $urandom_range(0, 999) < recv_idle_pct) begin
            hold_left = $urandom_range(1, LONG_GAP_MAX);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_mapped want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (report_count < REPORT_LIMIT)
                    $display("unexpected word: source_index %h in_range %b",
                             o_m_tdata, o_m_tuser);
                report_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.ok) in_range_seen++;
                if (o_m_tdata !== want.src || o_m_tuser !== want.ok) begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT)
                        $display("mismatch: source_index %h in_range %b, expected %h %b",
                                 o_m_tdata, o_m_tuser, want.src, want.ok);
                    report_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int unsigned quiet_cycles;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("tensor_permute_source_index regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic reg_burst;
        reg_burst = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            if (DIRECTED[k].kind == ROW_REG) begin
                if (!reg_burst) await_idle();
                write_reg(DIRECTED[k].addr, DIRECTED[k].value);
                reg_burst = 1'b1;
            end else begin
                if (reg_burst) i_cfg_wr_en <= 1'b0;
                reg_burst = 1'b0;
                send_word(DIRECTED[k].value[DATA_W-1:0], DIRECTED[k].kind == ROW_WORD_TYPED,
                          DIRECTED[k].want);
            end
        end

        for (int ph = 0; ph < IDLE_PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 25; recv_idle_pct = 80; end
                1: begin send_idle_pct = 80; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                await_idle();
                pick_setting();
                // hold the output off long enough for the input to back up
                if (s == 2) hold_requests++;
                for (int w = 0; w < WORDS_PER_SETTING; w++) send_word(pick_dest(), 1'b0, '0);
            end
        end

        await_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d words under %0d register writes, directed corners and random",
                 words_sent, reg_writes);
        $display("settings; %0d results checked, %0d of them in range",
                 results_checked, in_range_seen);
        if (fail_count == 0) begin
            $display("tensor_permute_source_index regression: pass");
        end else begin
            $display("%0d failures", fail_count);
            $display("tensor_permute_source_index regression: fail");
        end
        $finish;
    end

endmodule
